@@ sv/fatdep_pkg.sv @@
// Shared types, constants and entry decoding functions for the FAT directory entry parser.
`default_nettype none

package fatdep_pkg;

  localparam int MAX_FRAGMENTS_DEF = 20;
  localparam int UNITS    = 13;
  localparam int UNIT_W   = 16;
  localparam int ROW_W    = UNITS * UNIT_W;
  localparam int ENTRY_W  = 256;
  localparam int LEN_W    = 4;
  localparam int LEFT_W   = 6;
  localparam int CHARS_W  = 256;
  localparam int OUT_W    = 520;
  localparam int OUT_PAD  = OUT_W - (LEN_W + CHARS_W + ENTRY_W);

  localparam logic [7:0]        BYTE_DELETED = 8'hE5;
  localparam logic [7:0]        ATTR_LFN     = 8'h0F;
  localparam logic [7:0]        CHAR_SPACE   = 8'h20;
  localparam logic [UNIT_W-1:0] UNIT_DOT     = 16'h002E;
  localparam logic [LEN_W-1:0]  FULL_LEN     = LEN_W'(UNITS);

  localparam int UNIT_OFS [UNITS] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

  typedef enum logic [1:0] {
    KIND_FRAG = 2'd0,
    KIND_REC  = 2'd1,
    KIND_END  = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_SHORT   = 2'd2,
    PH_END     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CT_IDLE = 2'd0,
    CT_READ = 2'd1,
    CT_WAIT = 2'd2,
    CT_REC  = 2'd3
  } ctl_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [ROW_W-1:0] row;
  } sname_t;

  function automatic logic [ROW_W-1:0] lfn_units(input logic [ENTRY_W-1:0] e);
    logic [ROW_W-1:0] r;
    for (int i = 0; i < UNITS; i++) begin
      r[i*UNIT_W +: UNIT_W] = e[UNIT_OFS[i]*8 +: UNIT_W];
    end
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] first_zero(input logic [ROW_W-1:0] row);
    logic [LEN_W-1:0] len;
    len = FULL_LEN;
    for (int i = UNITS - 1; i >= 0; i--) begin
      if (row[i*UNIT_W +: UNIT_W] == '0) begin
        len = LEN_W'(i);
      end
    end
    return len;
  endfunction

  function automatic logic [ROW_W-1:0] trunc_row(input logic [ROW_W-1:0] row,
                                                  input logic [LEN_W-1:0] len);
    logic [ROW_W-1:0] r;
    r = row;
    for (int i = 0; i < UNITS; i++) begin
      if (LEN_W'(i) >= len) begin
        r[i*UNIT_W +: UNIT_W] = '0;
      end
    end
    return r;
  endfunction

  function automatic sname_t short_name(input logic [ENTRY_W-1:0] e);
    sname_t           r;
    logic [LEN_W-1:0] nlen;
    logic [LEN_W-1:0] elen;
    logic [LEN_W-1:0] k;
    logic             stop;
    logic             has_ext;
    nlen = '0;
    elen = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop) begin
        if (e[i*8 +: 8] == CHAR_SPACE) begin
          stop = 1'b1;
        end else begin
          nlen = nlen + 1'b1;
        end
      end
    end
    stop = 1'b0;
    for (int i = 8; i < 11; i++) begin
      if (!stop) begin
        if (e[i*8 +: 8] == CHAR_SPACE) begin
          stop = 1'b1;
        end else begin
          elen = elen + 1'b1;
        end
      end
    end
    has_ext = (e[71:64] != CHAR_SPACE);
    r.row = '0;
    for (int p = 0; p < UNITS; p++) begin
      k = LEN_W'(p) - nlen - 1'b1;
      if (LEN_W'(p) < nlen) begin
        r.row[p*UNIT_W +: UNIT_W] = {8'h00, e[p*8 +: 8]};
      end else if (has_ext && (LEN_W'(p) == nlen)) begin
        r.row[p*UNIT_W +: UNIT_W] = UNIT_DOT;
      end else if (has_ext && (LEN_W'(p) > nlen) && (k < elen)) begin
        r.row[p*UNIT_W +: UNIT_W] = {8'h00, e[64 + 8*k[1:0] +: 8]};
      end
    end
    r.len = nlen + (has_ext ? (LEN_W'(1) + elen) : LEN_W'(0));
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] pack_out(input logic [LEN_W-1:0]   len,
                                                input logic [ROW_W-1:0]   row,
                                                input logic [ENTRY_W-1:0] rec);
    return {{OUT_PAD{1'b0}}, rec, {(CHARS_W - ROW_W){1'b0}}, row, len};
  endfunction

endpackage

`default_nettype wire

@@ sv/fatdep_store.sv @@
// Synchronous fragment store: one write port and one registered read port, one row per fragment.
`default_nettype none

module fatdep_store
  import fatdep_pkg::*;
#(
  parameter int DEPTH  = MAX_FRAGMENTS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [ROW_W-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [ROW_W-1:0]  rd_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/fat_directory_entry_parser_unit.sv @@
// Top level of the FAT directory entry parser with long file name collection.
//
// The input channel carries one 32-byte directory entry per transaction on in_tdata,
// with in_tuser set to mark the end of the cluster chain. The output channel carries
// name fragments, entry records, directory end and malformed long name results; out_tlast
// marks the final result caused by one input transaction.
// A transaction that yields one result presents it on the output register in the cycle after
// acceptance, and a new input is taken every cycle while the output register is free or
// being drained. Valid long-name entries are written into the fragment store and yield nothing.
// The short entry closing a long name starts a burst read of the store: each fragment
// is first read from the memory and then loaded into the output register, in reverse
// order of storage, and the record follows the fragments. The single read port of the
// store sets this pace; no input is accepted during the burst.
// When the receiver stalls, the output register holds its transaction and the input
// side stops accepting until the register is free.
// Reset clears the control state and leaves the parser seeking a record. The fragment
// store is not cleared, since every row is written before it is read.
`default_nettype none

module fat_directory_entry_parser_unit
  import fatdep_pkg::*;
#(
  parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [ENTRY_W-1:0] in_tdata,   // entry_w0, entry_w1, entry_w2, entry_w3
  input  wire logic               in_tuser,   // opcode
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [OUT_W-1:0]   out_tdata,  // name_len, name_chars_a..d, record_w0..w3, zero pad
  output logic      [1:0]         out_tuser,  // kind
  output logic                    out_tlast
);

  localparam int SLOT_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int HELD_W = $clog2(MAX_FRAGMENTS + 1);

  ctl_t                ctl_r, ctl_nxt;
  phase_t              phase_r, phase_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic [HELD_W-1:0]   held_r, held_nxt;
  logic [LEN_W-1:0]    first_len_r, first_len_nxt;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;
  logic [ENTRY_W-1:0]  rec_r, rec_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]    out_tdata_r, out_tdata_nxt;
  kind_t               out_tuser_r, out_tuser_nxt;
  logic                out_tlast_r, out_tlast_nxt;

  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  logic [ROW_W-1:0]    wr_data;
  logic                rd_en;
  logic [ROW_W-1:0]    rd_data;

  logic                out_free;
  logic                in_acc;
  logic [7:0]          b0;
  logic [7:0]          b11;
  logic [LEFT_W-1:0]   lfn_count;
  logic                count_bad;
  logic [ROW_W-1:0]    lfn_row;
  logic [LEN_W-1:0]    lfn_len;
  sname_t              sname;
  logic [LEFT_W-1:0]   left_dec;

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (ctl_r == CT_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign b0        = in_tdata[7:0];
  assign b11       = in_tdata[95:88];
  assign lfn_count = b0[LEFT_W-1:0];
  assign count_bad = (lfn_count == '0) || (lfn_count > LEFT_W'(MAX_FRAGMENTS));
  assign lfn_row   = lfn_units(in_tdata);
  assign lfn_len   = first_zero(lfn_row);
  assign sname     = short_name(in_tdata);
  assign left_dec  = (left_r != '0) ? (left_r - 1'b1) : left_r;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  fatdep_store #(
    .DEPTH  (MAX_FRAGMENTS),
    .ADDR_W (SLOT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r        <= CT_IDLE;
      phase_r      <= PH_SEEK;
      left_r       <= '0;
      held_r       <= '0;
      first_len_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      ctl_r        <= ctl_nxt;
      phase_r      <= phase_nxt;
      left_r       <= left_nxt;
      held_r       <= held_nxt;
      first_len_r  <= first_len_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    rec_r       <= rec_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  always_comb begin
    ctl_nxt        = ctl_r;
    phase_nxt      = phase_r;
    left_nxt       = left_r;
    held_nxt       = held_r;
    first_len_nxt  = first_len_r;
    idx_nxt        = idx_r;
    rec_nxt        = rec_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = lfn_row;
    rd_en          = 1'b0;

    case (ctl_r)
      CT_IDLE: begin
        if (in_acc) begin
          if (in_tuser || (phase_r == PH_END)) begin
            phase_nxt      = PH_END;
            left_nxt       = '0;
            held_nxt       = '0;
            out_tvalid_nxt = 1'b1;
            out_tdata_nxt  = '0;
            out_tuser_nxt  = KIND_END;
            out_tlast_nxt  = 1'b1;
          end else if (phase_r == PH_COLLECT) begin
            if (held_r < HELD_W'(MAX_FRAGMENTS)) begin
              wr_en    = 1'b1;
              wr_addr  = SLOT_W'(held_r);
              held_nxt = held_r + 1'b1;
            end
            left_nxt = left_dec;
            if (left_dec == '0) begin
              phase_nxt = PH_SHORT;
            end
          end else if (phase_r == PH_SHORT) begin
            phase_nxt = PH_SEEK;
            held_nxt  = '0;
            left_nxt  = '0;
            rec_nxt   = in_tdata;
            idx_nxt   = SLOT_W'(held_r - 1'b1);
            ctl_nxt   = (held_r == '0) ? CT_REC : CT_READ;
          end else if (b0 == BYTE_DELETED) begin
            phase_nxt = PH_SEEK;
          end else if (in_tdata == '0) begin
            phase_nxt      = PH_END;
            out_tvalid_nxt = 1'b1;
            out_tdata_nxt  = '0;
            out_tuser_nxt  = KIND_END;
            out_tlast_nxt  = 1'b1;
          end else if (b11 == ATTR_LFN) begin
            if (count_bad) begin
              out_tvalid_nxt = 1'b1;
              out_tdata_nxt  = '0;
              out_tuser_nxt  = KIND_BAD;
              out_tlast_nxt  = 1'b1;
            end else begin
              wr_en         = 1'b1;
              wr_addr       = '0;
              wr_data       = trunc_row(lfn_row, lfn_len);
              first_len_nxt = lfn_len;
              held_nxt      = HELD_W'(1);
              left_nxt      = lfn_count - 1'b1;
              phase_nxt     = (lfn_count == LEFT_W'(1)) ? PH_SHORT : PH_COLLECT;
            end
          end else begin
            out_tvalid_nxt = 1'b1;
            out_tdata_nxt  = pack_out(sname.len, sname.row, in_tdata);
            out_tuser_nxt  = KIND_REC;
            out_tlast_nxt  = 1'b1;
          end
        end
      end
      CT_READ: begin
        rd_en   = 1'b1;
        ctl_nxt = CT_WAIT;
      end
      CT_WAIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = pack_out((idx_r == '0) ? first_len_r : FULL_LEN, rd_data, '0);
          out_tuser_nxt  = KIND_FRAG;
          out_tlast_nxt  = 1'b0;
          if (idx_r == '0) begin
            ctl_nxt = CT_REC;
          end else begin
            idx_nxt = idx_r - 1'b1;
            ctl_nxt = CT_READ;
          end
        end
      end
      CT_REC: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = pack_out('0, '0, rec_r);
          out_tuser_nxt  = KIND_REC;
          out_tlast_nxt  = 1'b1;
          ctl_nxt        = CT_IDLE;
        end
      end
      default: begin
        ctl_nxt = CT_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
